FILE: rtl/ppp_rx_pkg.sv
package ppp_rx_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_FLAG  = 2'd1,
    MODE_FRAME = 2'd2,
    MODE_ESC   = 2'd3
  } rx_mode_t;

  localparam logic [7:0] BYTE_FLAG = 8'h7E;
  localparam logic [7:0] BYTE_ADDR = 8'hFF;
  localparam logic [7:0] BYTE_ESC  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  localparam logic [2:0] HDR_LEN   = 3'd5;
  localparam logic [2:0] CNT_MAX   = 3'd6;
  localparam logic [1:0] HOLD_FULL = 2'd3;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_end;
    logic       runt;
    logic       terminate_seen;
    logic [7:0] terminate_id;
  } ppp_result_t;

  // LCP Terminate-Request header: ff 03 c0 21 05
  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0:    v = 8'hFF;
      3'd1:    v = 8'h03;
      3'd2:    v = 8'hC0;
      3'd3:    v = 8'h21;
      3'd4:    v = 8'h05;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/ppp_rx_dec.sv
module ppp_rx_dec (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_valid,
  input  logic [7:0]            rx_byte,
  output logic                  res_valid,
  output ppp_rx_pkg::ppp_result_t res
);
  import ppp_rx_pkg::*;

  rx_mode_t    mode_r, mode_nxt;
  logic [7:0]  hold_r [3];
  logic [7:0]  hold_nxt [3];
  logic [1:0]  hcnt_r, hcnt_nxt, hcnt_e;
  logic [2:0]  cnt_r, cnt_nxt, cnt_e;
  logic        match_r, match_nxt, match_e;
  logic [7:0]  id_r, id_nxt, id_e;
  logic        push, close, start, seen;
  logic [7:0]  dbyte;

  always_comb begin
    mode_nxt  = mode_r;
    push      = 1'b0;
    close     = 1'b0;
    start     = 1'b0;
    dbyte     = rx_byte;
    if (byte_valid) begin
      unique case (mode_r)
        MODE_IDLE: begin
          if (rx_byte == BYTE_FLAG) mode_nxt = MODE_FLAG;
        end
        MODE_FLAG: begin
          if (rx_byte == BYTE_ADDR) begin
            start    = 1'b1;
            push     = 1'b1;
            mode_nxt = MODE_FRAME;
          end else if (rx_byte != BYTE_FLAG) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_FRAME: begin
          if (rx_byte == BYTE_FLAG) close = 1'b1;
          else if (rx_byte == BYTE_ESC) mode_nxt = MODE_ESC;
          else push = 1'b1;
        end
        MODE_ESC: begin
          if (rx_byte == BYTE_FLAG) begin
            close = 1'b1;
          end else begin
            mode_nxt = MODE_FRAME;
            push     = 1'b1;
            dbyte    = rx_byte ^ ESC_XOR;
          end
        end
        default: mode_nxt = MODE_IDLE;
      endcase
    end

    hcnt_e  = start ? 2'd0 : hcnt_r;
    cnt_e   = start ? 3'd0 : cnt_r;
    match_e = start ? 1'b1 : match_r;
    id_e    = start ? 8'h00 : id_r;

    hold_nxt  = hold_r;
    hcnt_nxt  = hcnt_e;
    cnt_nxt   = cnt_e;
    match_nxt = match_e;
    id_nxt    = id_e;
    res_valid = 1'b0;
    res       = '0;
    seen      = match_r && (cnt_r >= HDR_LEN);

    if (push) begin
      if (cnt_e < HDR_LEN) begin
        if (dbyte != hdr_byte(cnt_e)) match_nxt = 1'b0;
      end else if (cnt_e == HDR_LEN) begin
        id_nxt = dbyte;
      end
      if (cnt_e < CNT_MAX) cnt_nxt = cnt_e + 3'd1;
      if (hcnt_e == HOLD_FULL) begin
        res_valid        = 1'b1;
        res.payload_byte = hold_r[0];
        hold_nxt[0]      = hold_r[1];
        hold_nxt[1]      = hold_r[2];
        hold_nxt[2]      = dbyte;
      end else begin
        hold_nxt[hcnt_e] = dbyte;
        hcnt_nxt         = hcnt_e + 2'd1;
      end
    end else if (close) begin
      res_valid     = 1'b1;
      res.frame_end = 1'b1;
      if (hcnt_r == HOLD_FULL) begin
        res.payload_byte   = hold_r[0];
        res.terminate_seen = seen;
        res.terminate_id   = seen ? id_r : 8'h00;
      end else begin
        res.runt = 1'b1;
      end
      hcnt_nxt = 2'd0;
      mode_nxt = MODE_FLAG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      hcnt_r  <= 2'd0;
      cnt_r   <= 3'd0;
      match_r <= 1'b1;
      id_r    <= 8'h00;
    end else begin
      mode_r  <= mode_nxt;
      hcnt_r  <= hcnt_nxt;
      cnt_r   <= cnt_nxt;
      match_r <= match_nxt;
      id_r    <= id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

FILE: rtl/ppp_rx_obuf.sv
module ppp_rx_obuf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  ppp_rx_pkg::ppp_result_t push_data,
  output logic                    up_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ppp_rx_pkg::ppp_result_t out_data
);
  import ppp_rx_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  ppp_result_t out_r, out_nxt;
  ppp_result_t skid_r, skid_nxt;

  assign up_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = push_data;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

FILE: rtl/ppp_async_frame_receiver.sv
// PPP asynchronous frame receiver.
// Input channel: in_valid/in_ready with one raw serial byte in in_rx_byte per
// transaction. Frames open on 7E followed by a literal FF and close on the
// next 7E; 7D unescapes the following byte. Bytes outside a frame are dropped.
// Result channel: out_valid/out_ready with the decoded payload byte, the
// end-of-frame mark, a runt flag for frames under three decoded bytes, and
// the LCP Terminate-Request detection with its identifier on the end result.
// The two FCS bytes are held back and never presented.
// Throughput: one byte per cycle while the output side keeps in_ready high. A
// byte accepted into the input register is decoded there, and its result (if
// any) is registered in the output buffer and presented from it.
// Decoded bytes give no result until the three-byte hold is full; a closing
// flag gives the last result.
// Reset (rst_n low, synchronous) returns the deframer to hunting for a flag
// and empties the input register and the two-entry output buffer.
// When out_ready stays low, the output buffer absorbs one further result,
// the input register takes at most one more byte and then in_ready drops;
// nothing is lost or duplicated.
module ppp_async_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic       out_frame_end,
  output logic       out_runt,
  output logic       out_terminate_seen,
  output logic [7:0] out_terminate_id
);
  import ppp_rx_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r, s1_byte_nxt;
  logic        buf_ready;
  logic        s1_fire;
  logic        res_valid;
  ppp_result_t res;
  ppp_result_t out_res;

  assign s1_fire  = s1_valid_r && buf_ready;
  assign in_ready = !s1_valid_r || buf_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
      s1_byte_nxt  = in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
  end

  ppp_rx_dec u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (s1_fire),
    .rx_byte    (s1_byte_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  ppp_rx_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .up_ready  (buf_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_payload_byte   = out_res.payload_byte;
  assign out_frame_end      = out_res.frame_end;
  assign out_runt           = out_res.runt;
  assign out_terminate_seen = out_res.terminate_seen;
  assign out_terminate_id   = out_res.terminate_id;

  a_runt_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_runt) |-> (out_frame_end && out_payload_byte == 8'h00
      && !out_terminate_seen && out_terminate_id == 8'h00))
    else $error("runt result carries data");

  a_term_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_terminate_seen) |-> (out_frame_end && !out_runt))
    else $error("terminate flag outside a frame end");

  a_no_id_wo_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_terminate_seen) |-> (out_terminate_id == 8'h00))
    else $error("terminate id without terminate flag");

  a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && res_valid) |=> !buf_ready)
    else $error("input taken while output buffer full");

endmodule

FILE: tb/ppp_async_frame_receiver_test.sv
module ppp_async_frame_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ppp_rx_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int TAIL_BYTES    = 150;
  localparam int STREAM_TARGET = 1600;
  localparam logic [0:4][7:0] TERM_HDR = {8'hFF, 8'h03, 8'hC0, 8'h21, 8'h05};

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] out_payload_byte;
  logic       out_frame_end;
  logic       out_runt;
  logic       out_terminate_seen;
  logic [7:0] out_terminate_id;

  ppp_async_frame_receiver dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_frame_end     (out_frame_end),
    .out_runt          (out_runt),
    .out_terminate_seen(out_terminate_seen),
    .out_terminate_id  (out_terminate_id)
  );

  logic [7:0]  stream_bytes[$];
  ppp_result_t expected_results[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          in_taken = 1'b0;
  int          in_gap = 0;
  int          in_calm = 0;
  int          out_gap = 0;
  int          out_calm = 0;

  // deframer state
  rx_mode_t   mode     = MODE_IDLE;
  logic [7:0] held [3] = '{8'h00, 8'h00, 8'h00};
  logic [1:0] held_cnt = 2'd0;
  logic [2:0] dec_cnt  = 3'd0;
  logic       hdr_ok   = 1'b1;
  logic [7:0] term_id  = 8'h00;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void take_decoded(logic [7:0] b);
    ppp_result_t r;
    if (dec_cnt < HDR_LEN) begin
      if (b != TERM_HDR[dec_cnt]) hdr_ok = 1'b0;
    end else if (dec_cnt == HDR_LEN) begin
      term_id = b;
    end
    if (dec_cnt < CNT_MAX) dec_cnt++;
    if (held_cnt == HOLD_FULL) begin
      r = '0;
      r.payload_byte = held[0];
      expected_results.push_back(r);
      held[0] = held[1];
      held[1] = held[2];
      held[2] = b;
    end else begin
      held[held_cnt] = b;
      held_cnt++;
    end
  endfunction

  function automatic void end_frame();
    ppp_result_t r;
    r = '0;
    r.frame_end = 1'b1;
    if (held_cnt == HOLD_FULL) begin
      r.payload_byte = held[0];
      r.terminate_seen = hdr_ok && (dec_cnt >= HDR_LEN);
      if (r.terminate_seen) r.terminate_id = term_id;
    end else begin
      r.runt = 1'b1;
    end
    expected_results.push_back(r);
    held_cnt = 2'd0;
    mode = MODE_FLAG;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    case (mode)
      MODE_IDLE: begin
        if (b == BYTE_FLAG) mode = MODE_FLAG;
      end
      MODE_FLAG: begin
        if (b == BYTE_ADDR) begin
          held_cnt = 2'd0;
          dec_cnt = 3'd0;
          hdr_ok = 1'b1;
          term_id = 8'h00;
          mode = MODE_FRAME;
          take_decoded(b);
        end else if (b != BYTE_FLAG) begin
          mode = MODE_IDLE;
        end
      end
      MODE_FRAME: begin
        if (b == BYTE_FLAG) end_frame();
        else if (b == BYTE_ESC) mode = MODE_ESC;
        else take_decoded(b);
      end
      default: begin
        if (b == BYTE_FLAG) begin
          end_frame();
        end else begin
          mode = MODE_FRAME;
          take_decoded(b ^ ESC_XOR);
        end
      end
    endcase
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
      mismatches++;
    end
  endfunction

  function automatic int pick_gap(inout int calm);
    if (stream_bytes.size() < TAIL_BYTES) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    case ($urandom_range(0, 15))
      0: return $urandom_range(1, 15);
      1: begin
        calm = $urandom_range(20, 100);
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void put_body_byte(logic [7:0] b);
    if (b == BYTE_FLAG || b == BYTE_ESC ||
        ((b ^ ESC_XOR) != BYTE_FLAG && $urandom_range(0, 15) == 0)) begin
      stream_bytes.push_back(BYTE_ESC);
      stream_bytes.push_back(b ^ ESC_XOR);
    end else begin
      stream_bytes.push_back(b);
    end
  endfunction

  always @(posedge clk) begin
    ppp_result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got byte %0h end %0b runt %0b",
                   $time, out_payload_byte, out_frame_end, out_runt);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("payload_byte", want.payload_byte, out_payload_byte);
          compare_field("frame_end", want.frame_end, out_frame_end);
          compare_field("runt", want.runt, out_runt);
          compare_field("terminate_seen", want.terminate_seen, out_terminate_seen);
          compare_field("terminate_id", want.terminate_id, out_terminate_id);
        end
      end
      if (in_valid && in_ready) begin
        deframe_byte(in_rx_byte);
        in_taken = 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    bit was_taken;
    was_taken = in_taken;
    if (in_taken) begin
      void'(stream_bytes.pop_front());
      in_taken = 1'b0;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || was_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else begin
        in_gap = pick_gap(in_calm);
        if (in_gap == 0 && stream_bytes.size() > 0) begin
          in_valid <= 1'b1;
          in_rx_byte <= stream_bytes[0];
        end else begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_gap = pick_gap(out_calm);
      out_ready <= (out_gap == 0);
      if (out_gap > 0) out_gap--;
    end
  end

  initial begin
    logic [7:0] directed [] = '{
      8'h00, BYTE_FLAG, 8'h11,
      BYTE_FLAG, BYTE_ESC, 8'hDF,
      BYTE_FLAG, BYTE_FLAG, BYTE_ADDR, 8'h03, 8'hC0, 8'h21, 8'h05, BYTE_FLAG,
      BYTE_ADDR, BYTE_FLAG,
      BYTE_ADDR, BYTE_ESC, 8'h5D, BYTE_ESC, BYTE_FLAG,
      BYTE_ADDR, 8'h03, 8'hC0, 8'h21, 8'h05, 8'hA5, 8'h00, BYTE_ESC, 8'h5E, BYTE_FLAG
    };
    int         kind;
    int         len;
    bit         shared_open;
    logic [7:0] b;

    foreach (directed[i]) stream_bytes.push_back(directed[i]);
    shared_open = 1'b1;
    while (stream_bytes.size() < STREAM_TARGET) begin
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        repeat ($urandom_range(1, 6)) begin
          b = ($urandom_range(0, 5) == 0) ? BYTE_FLAG : 8'($urandom_range(0, 255));
          stream_bytes.push_back(b);
        end
        shared_open = 1'b0;
      end else if (kind < 4) begin
        stream_bytes.push_back(BYTE_FLAG);
        if ($urandom_range(0, 1) == 0) begin
          b = 8'($urandom_range(0, 255));
          if (b == BYTE_ADDR) b = 8'h00;
          stream_bytes.push_back(b);
          shared_open = 1'b0;
        end else begin
          stream_bytes.push_back(BYTE_ADDR);
          len = $urandom_range(0, 5);
          repeat (len) put_body_byte(8'($urandom_range(0, 255)));
          stream_bytes.push_back(BYTE_ESC);
          stream_bytes.push_back(BYTE_FLAG);
          shared_open = 1'b1;
        end
      end else begin
        if (!shared_open) stream_bytes.push_back(BYTE_FLAG);
        stream_bytes.push_back(BYTE_ADDR);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) begin
          put_body_byte(8'h03);
          put_body_byte(8'hC0);
          put_body_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h21);
          put_body_byte(8'h05);
          put_body_byte(8'($urandom_range(0, 255)));
        end
        repeat (len) put_body_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0) stream_bytes.push_back(BYTE_ESC);
        stream_bytes.push_back(BYTE_FLAG);
        shared_open = 1'($urandom_range(0, 1));
      end
    end

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    while (stream_bytes.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() > 0) begin
      $display("%0t: %0d expected transactions never arrived", $time, expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
